FILE: sv/hlmdu_pkg.sv
// Shared types, operation codes and constants of the HI/LO multiply/divide unit.
package hlmdu_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned COUNT_W = 5;

   localparam logic [DATA_W-1:0]  ALL_ONES  = 32'hffff_ffff;
   localparam logic [DATA_W-1:0]  SIGN_BIT  = 32'h8000_0000;
   localparam logic [DATA_W-1:0]  ONE       = 32'd1;
   localparam logic [COUNT_W-1:0] LAST_STEP = 5'd31;

   localparam logic [FUNC_W-1:0] FUNC_MULT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIV_S    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DIV_U    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_HI  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_LO  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_HI = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_LO = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_MUL,
      OP_WRITE_MUL,
      OP_LOAD_DIV_S,
      OP_LOAD_DIV_U,
      OP_STEP_DIV,
      OP_FINISH_DIV,
      OP_DIV_ZERO_S,
      OP_DIV_ZERO_U,
      OP_DIV_OVF,
      OP_WRITE_HI,
      OP_WRITE_LO,
      OP_READ_HI,
      OP_READ_LO
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic divisor_zero;
      logic div_overflow;
   } dp_status_type;

endpackage

FILE: sv/hlmdu_if.sv
// Valid/ready channel interfaces for request and response items.
interface hlmdu_req_if import hlmdu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] src_a;
   logic [DATA_W-1:0] src_b;

   modport source (output valid, output func, output src_a, output src_b, input ready);
   modport sink (input valid, input func, input src_a, input src_b, output ready);
endinterface

interface hlmdu_rsp_if import hlmdu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_value;

   modport source (output valid, output read_value, input ready);
   modport sink (input valid, input read_value, output ready);
endinterface

FILE: sv/hlmdu_datapath.sv
// Datapath: HI and LO registers, multiplier, restoring divider and response data register.
module hlmdu_datapath import hlmdu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [DATA_W-1:0]   src_a,
   input  logic [DATA_W-1:0]   src_b,
   output dp_status_type       status,
   output logic [DATA_W-1:0]   read_value
);

   logic [DATA_W-1:0]   hi_ff, hi_in;
   logic [DATA_W-1:0]   lo_ff, lo_in;
   logic [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]   dvs_ff, dvs_in;
   logic                neg_q_ff, neg_q_in;
   logic                neg_r_ff, neg_r_in;
   logic [DATA_W-1:0]   out_ff, out_in;

   logic [DATA_W-1:0]   mag_a;
   logic [DATA_W-1:0]   mag_b;
   logic [DATA_W:0]     trial;

   assign status.divisor_zero = (src_b == '0);
   assign status.div_overflow = (src_a == SIGN_BIT) && (src_b == ALL_ONES);

   assign mag_a = src_a[DATA_W-1] ? (DATA_W'(0) - src_a) : src_a;
   assign mag_b = src_b[DATA_W-1] ? (DATA_W'(0) - src_b) : src_b;
   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      out_in   = out_ff;
      case (cmd.op)
         OP_LOAD_MUL: begin
            prod_in = 64'($signed(src_a) * $signed(src_b));
         end
         OP_WRITE_MUL: begin
            hi_in = prod_ff[2*DATA_W-1:DATA_W];
            lo_in = prod_ff[DATA_W-1:0];
         end
         OP_LOAD_DIV_S: begin
            rem_in   = '0;
            quo_in   = mag_a;
            dvs_in   = mag_b;
            neg_q_in = src_a[DATA_W-1] ^ src_b[DATA_W-1];
            neg_r_in = src_a[DATA_W-1];
         end
         OP_LOAD_DIV_U: begin
            rem_in   = '0;
            quo_in   = src_a;
            dvs_in   = src_b;
            neg_q_in = 1'b0;
            neg_r_in = 1'b0;
         end
         OP_STEP_DIV: begin
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
         end
         OP_FINISH_DIV: begin
            lo_in = neg_q_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
            hi_in = neg_r_ff ? (DATA_W'(0) - rem_ff) : rem_ff;
         end
         OP_DIV_ZERO_S: begin
            hi_in = src_a;
            lo_in = src_a[DATA_W-1] ? ONE : ALL_ONES;
         end
         OP_DIV_ZERO_U: begin
            hi_in = src_a;
            lo_in = ALL_ONES;
         end
         OP_DIV_OVF: begin
            hi_in = '0;
            lo_in = SIGN_BIT;
         end
         OP_WRITE_HI: begin
            hi_in = src_a;
         end
         OP_WRITE_LO: begin
            lo_in = src_a;
         end
         OP_READ_HI: begin
            out_in = hi_ff;
         end
         OP_READ_LO: begin
            out_in = lo_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      out_ff   <= out_in;
   end

   assign read_value = out_ff;

endmodule

FILE: sv/hlmdu_controller.sv
// Controller: handshakes, operation sequencing, divide step counter and response valid.
module hlmdu_controller import hlmdu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dp_status_type     status,
   output dp_cmd_type        cmd
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_read;
   logic               accept;

   assign is_read   = (req_func == FUNC_READ_HI) || (req_func == FUNC_READ_LO);
   assign req_ready = (state_ff == ST_IDLE) && (!is_read || !rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_MULT) begin
                  state_in = ST_MUL;
               end else if ((req_func == FUNC_DIV_S) && !status.divisor_zero
                            && !status.div_overflow) begin
                  state_in = ST_DIV;
               end else if ((req_func == FUNC_DIV_U) && !status.divisor_zero) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (count_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_MULT: begin
                     cmd.op = OP_LOAD_MUL;
                  end
                  FUNC_DIV_S: begin
                     if (status.divisor_zero) begin
                        cmd.op = OP_DIV_ZERO_S;
                     end else if (status.div_overflow) begin
                        cmd.op = OP_DIV_OVF;
                     end else begin
                        cmd.op = OP_LOAD_DIV_S;
                     end
                  end
                  FUNC_DIV_U: begin
                     cmd.op = status.divisor_zero ? OP_DIV_ZERO_U : OP_LOAD_DIV_U;
                  end
                  FUNC_READ_HI: begin
                     cmd.op       = OP_READ_HI;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_READ_LO: begin
                     cmd.op       = OP_READ_LO;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_WRITE_HI: begin
                     cmd.op = OP_WRITE_HI;
                  end
                  FUNC_WRITE_LO: begin
                     cmd.op = OP_WRITE_LO;
                  end
                  default: begin
                     cmd.op = OP_NONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            cmd.op = OP_WRITE_MUL;
         end
         ST_DIV: begin
            cmd.op   = OP_STEP_DIV;
            count_in = count_ff + COUNT_W'(1);
         end
         ST_FIN: begin
            cmd.op = OP_FINISH_DIV;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The step counter is at zero whenever no divide is in flight.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (count_ff == '0))
      else $error("divide step counter not at zero outside divide");

   // The last divide step is always followed by the finishing cycle.
   a_div_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && count_ff == LAST_STEP) |=> (state_ff == ST_FIN))
      else $error("divide did not finish after last step");

   // A read item never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && is_read) |-> (!rsp_valid_ff || rsp_ready))
      else $error("read item accepted over a pending response");

   // Items are taken only while no multiply or divide is in flight.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("request ready while an operation is in flight");

endmodule

FILE: sv/hi_lo_multiply_divide_unit_top.sv
// Top level of the HI/LO multiply/divide unit.
// The unit takes one item at a time. A multiply fills the product register, then writes
// HI:LO. A divide loads the operand magnitudes, then runs 32 steps of the restoring
// divider at one quotient bit per cycle, and then applies the signs; divide by zero and
// the signed overflow case complete in the cycle of acceptance. Moves to and from HI and
// LO leave the unit in idle. A read result sits in an output register until it is taken,
// and further items are accepted meanwhile; only another read waits for that register.
module hi_lo_multiply_divide_unit_top import hlmdu_pkg::*; (
   input logic       clock,
   input logic       reset,
   hlmdu_req_if.sink   req_chan,
   hlmdu_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   hlmdu_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hlmdu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .src_a      (req_chan.src_a),
      .src_b      (req_chan.src_b),
      .status     (status),
      .read_value (rsp_chan.read_value)
   );

endmodule

FILE: bench/hi_lo_multiply_divide_unit_top_test.sv
// Self-checking testbench for the HI/LO multiply/divide unit, with directed and random items.
`timescale 1ns / 1ps

module hi_lo_multiply_divide_unit_top_test;
   import hlmdu_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] src_a;
      logic [DATA_W-1:0] src_b;
      logic              typed;
      logic [DATA_W-1:0] value;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;

   // Rows with typed set carry the read value that must come back.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{FUNC_MULT,     32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h3fff_ffff},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
      '{FUNC_MULT,     32'hffff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
      '{FUNC_DIV_S,    32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1234_5678},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{FUNC_DIV_S,    32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
      '{FUNC_DIV_U,    32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{FUNC_DIV_S,    32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
      '{FUNC_DIV_S,    32'hffff_fff9, 32'h0000_0002, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_DIV_S,    32'h0000_0007, 32'hffff_fffe, 1'b0, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_WRITE_HI, 32'hdead_beef, 32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{FUNC_UNUSED,   32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{FUNC_WRITE_LO, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_HI,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{FUNC_READ_LO,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000}
   };

   logic clock;
   logic reset;

   hlmdu_req_if req_bus ();
   hlmdu_rsp_if rsp_bus ();

   hi_lo_multiply_divide_unit_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [DATA_W-1:0] hi_model;
   logic [DATA_W-1:0] lo_model;
   logic [DATA_W-1:0] read_values_due [$];
   logic [DATA_W-1:0] due_value;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                burst_left = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL hi_lo_multiply_divide_unit_top");
         $finish;
      end
   end

   // Updates the HI/LO copy for one accepted item and queues the value a read returns.
   task automatic update_hilo(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b, input logic typed,
                              input logic [DATA_W-1:0] typed_value);
      logic [63:0]       product;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] quot;
      logic [DATA_W-1:0] rem;
      case (func)
         FUNC_MULT: begin
            product = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            hi_model = product[63:32];
            lo_model = product[31:0];
         end
         FUNC_DIV_S: begin
            if (b == '0) begin
               hi_model = a;
               lo_model = a[31] ? ONE : ALL_ONES;
            end else if (a == SIGN_BIT && b == ALL_ONES) begin
               hi_model = '0;
               lo_model = SIGN_BIT;
            end else begin
               mag_a = a[31] ? (32'd0 - a) : a;
               mag_b = b[31] ? (32'd0 - b) : b;
               quot = mag_a / mag_b;
               rem = mag_a % mag_b;
               lo_model = (a[31] != b[31]) ? (32'd0 - quot) : quot;
               hi_model = a[31] ? (32'd0 - rem) : rem;
            end
         end
         FUNC_DIV_U: begin
            if (b == '0) begin
               hi_model = a;
               lo_model = ALL_ONES;
            end else begin
               hi_model = a % b;
               lo_model = a / b;
            end
         end
         FUNC_READ_HI: read_values_due.push_back(typed ? typed_value : hi_model);
         FUNC_READ_LO: read_values_due.push_back(typed ? typed_value : lo_model);
         FUNC_WRITE_HI: hi_model = a;
         FUNC_WRITE_LO: lo_model = a;
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] a,
                            input logic [DATA_W-1:0] b, input logic typed,
                            input logic [DATA_W-1:0] typed_value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.src_a <= a;
      req_bus.src_b <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      update_hilo(func, a, b, typed, typed_value);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (read_values_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] small_mag;
      small_mag = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONE;
         2: return ALL_ONES;
         3: return SIGN_BIT;
         4: return 32'h7fff_ffff;
         5: return ($urandom_range(0, 1) != 0) ? (32'd0 - small_mag) : small_mag;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      int                pick;
      int                issued;
      hi_model = '0;
      lo_model = '0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_MULT;
      req_bus.src_a <= '0;
      req_bus.src_b <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].func, directed_rows[i].src_a, directed_rows[i].src_b,
                   directed_rows[i].typed, directed_rows[i].value);
      wait_drained();

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         a = pick_operand();
         b = pick_operand();
         if (pick < 15) func = FUNC_MULT;
         else if (pick < 35) func = FUNC_DIV_S;
         else if (pick < 50) func = FUNC_DIV_U;
         else if (pick < 65) func = FUNC_READ_HI;
         else if (pick < 80) func = FUNC_READ_LO;
         else if (pick < 88) func = FUNC_WRITE_HI;
         else if (pick < 96) func = FUNC_WRITE_LO;
         else func = FUNC_UNUSED;
         if (func == FUNC_DIV_S && $urandom_range(0, 19) == 0) begin
            a = SIGN_BIT;
            b = ALL_ONES;
         end
         send_item(func, a, b, 1'b0, '0);
         if (func != FUNC_UNUSED) begin
            issued++;
            if (issued == RANDOM_ITEMS / 2) wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && read_values_due.size() == 0)
         $display("PASS hi_lo_multiply_divide_unit_top");
      else
         $display("FAIL hi_lo_multiply_divide_unit_top");
      $finish;
   end

   // The receiver changes its stall rate every so often, including long spans with no stall.
   initial begin
      int stall_pct;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
         repeat ($urandom_range(20, 200)) begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (read_values_due.size() == 0) begin
            $error("read_value arrived with none expected: actual %h", rsp_bus.read_value);
            mismatch_count++;
         end else begin
            due_value = read_values_due.pop_front();
            if (rsp_bus.read_value !== due_value) begin
               $error("read_value mismatch: expected %h, actual %h", due_value,
                      rsp_bus.read_value);
               mismatch_count++;
            end
         end
      end
   end

endmodule

FILE: hi_lo_multiply_divide_unit_top.f
sv/hlmdu_pkg.sv
sv/hlmdu_if.sv
sv/hlmdu_datapath.sv
sv/hlmdu_controller.sv
sv/hi_lo_multiply_divide_unit_top.sv
bench/hi_lo_multiply_divide_unit_top_test.sv
